// ----- sv/sobel_3x3_vertical_filter_top_macros.svh -----
// assertion macros for the vertical sobel filter
// used by the top level; empty bodies when SYNTHESIS is defined
`ifndef SOBEL_3X3_VERTICAL_FILTER_TOP_MACROS_SVH
`define SOBEL_3X3_VERTICAL_FILTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SOBF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define SOBF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SOBF_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define SOBF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/sobf_pkg.sv -----
// shared types, constants and functions of the vertical sobel filter
// no dependencies
`default_nettype none
package sobf_pkg;

   localparam int unsigned DEF_MAX_WIDTH  = 512;
   localparam int unsigned DEF_MAX_HEIGHT = 512;

   localparam int unsigned PIX_W     = 8;
   localparam int unsigned DIM_W     = 10;
   localparam int unsigned LINE_W    = 2 * PIX_W;
   localparam int unsigned CSR_IDX_W = 1;

   localparam logic [PIX_W-1:0] PIX_MAX           = 8'd255;
   localparam logic [DIM_W-1:0] DEF_FRAME_WIDTH  = 10'd512;
   localparam logic [DIM_W-1:0] DEF_FRAME_HEIGHT = 10'd512;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_reg_type;

   typedef struct packed {
      logic             v0;
      logic             v1;
      logic [PIX_W-1:0] px0;
      logic [PIX_W-1:0] px1;
      logic             last1;
   } res_load_type;

   function automatic int unsigned eff_dim(input logic [DIM_W-1:0] v, input int unsigned maxv);
      int unsigned res;
      if (v == '0) begin
         res = 1;
      end else if (32'(v) > maxv) begin
         res = maxv;
      end else begin
         res = 32'(v);
      end
      return res;
   endfunction

   function automatic logic [PIX_W-1:0] sobf_grad(
      input logic [PIX_W-1:0] t0, input logic [PIX_W-1:0] t1, input logic [PIX_W-1:0] t2,
      input logic [PIX_W-1:0] b0, input logic [PIX_W-1:0] b1, input logic [PIX_W-1:0] b2);
      logic [PIX_W+1:0] ts;
      logic [PIX_W+1:0] bs;
      logic [PIX_W+2:0] d;
      logic [PIX_W-1:0] res;
      ts = {2'b00, t0} + {1'b0, t1, 1'b0} + {2'b00, t2};
      bs = {2'b00, b0} + {1'b0, b1, 1'b0} + {2'b00, b2};
      d  = {1'b0, bs} - {1'b0, ts};
      if (d[PIX_W+2]) begin
         res = '0;
      end else if (|d[PIX_W+1:PIX_W]) begin
         res = PIX_MAX;
      end else begin
         res = d[PIX_W-1:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

// ----- sv/sobf_if.sv -----
// channel interfaces: pixel requests, filtered responses, register writes
// depends on sobf_pkg
`default_nettype none
interface sobf_req_if;
   import sobf_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] pixel_value;
   logic             frame_start;
   modport source (output valid, output pixel_value, output frame_start, input ready);
   modport sink (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface sobf_rsp_if;
   import sobf_pkg::*;
   logic             valid;
   logic             ready;
   logic [PIX_W-1:0] filtered_pixel;
   logic             last_of_frame;
   modport source (output valid, output filtered_pixel, output last_of_frame, input ready);
   modport sink (input valid, input filtered_pixel, input last_of_frame, output ready);
endinterface

interface sobf_csr_if;
   import sobf_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [DIM_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/sobf_csr.sv -----
// frame size registers, held as clamped effective dimensions
// depends on sobf_pkg and sobf_csr_if
`default_nettype none
module sobf_csr #(
   parameter int unsigned MAX_WIDTH  = sobf_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = sobf_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   sobf_csr_if.sink                             csr_bus,
   output logic [$clog2(MAX_WIDTH+1)-1:0]       eff_w,
   output logic [$clog2(MAX_HEIGHT+1)-1:0]      eff_h
);
   import sobf_pkg::*;

   localparam int unsigned WD = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HD = $clog2(MAX_HEIGHT + 1);
   localparam logic [WD-1:0] RST_W = WD'(eff_dim(DEF_FRAME_WIDTH, MAX_WIDTH));
   localparam logic [HD-1:0] RST_H = HD'(eff_dim(DEF_FRAME_HEIGHT, MAX_HEIGHT));

   logic [WD-1:0] eff_w_ff, eff_w_in;
   logic [HD-1:0] eff_h_ff, eff_h_in;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      eff_w_in = eff_w_ff;
      eff_h_in = eff_h_ff;
      if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_FRAME_WIDTH:  eff_w_in = WD'(eff_dim(csr_bus.data, MAX_WIDTH));
            REG_FRAME_HEIGHT: eff_h_in = HD'(eff_dim(csr_bus.data, MAX_HEIGHT));
            default: begin
               eff_w_in = eff_w_ff;
               eff_h_in = eff_h_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_w_ff <= RST_W;
         eff_h_ff <= RST_H;
      end else begin
         eff_w_ff <= eff_w_in;
         eff_h_ff <= eff_h_in;
      end
   end

   assign eff_w = eff_w_ff;
   assign eff_h = eff_h_ff;

endmodule
`default_nettype wire

// ----- sv/sobf_line_mem.sv -----
// line store memory: {older, newer} pixel pair per column, registered read
// write-first bypass on address match; zero-fill sweep after reset; uses sobf_pkg
`default_nettype none
module sobf_line_mem #(
   parameter int unsigned DEPTH = sobf_pkg::DEF_MAX_WIDTH
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [sobf_pkg::LINE_W-1:0]        rd_data,
   input  wire logic                          wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  wire logic [sobf_pkg::LINE_W-1:0]   wr_data,
   output logic                               busy
);
   import sobf_pkg::*;

   localparam int unsigned ADDR_W = $clog2(DEPTH);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

   logic [LINE_W-1:0] mem [DEPTH];
   logic [LINE_W-1:0] rd_data_ff;
   logic              clr_busy_ff, clr_busy_in;
   logic [ADDR_W-1:0] clr_addr_ff, clr_addr_in;

   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + ADDR_W'(1);
         if (clr_addr_ff == LAST_ADDR) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= (wr_en && (wr_addr == rd_addr)) ? wr_data : mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clr_busy_ff;

endmodule
`default_nettype wire

// ----- sv/sobf_out_buf.sv -----
// two-entry result buffer feeding the response channel one beat at a time
// depends on sobf_pkg and sobf_rsp_if
`default_nettype none
module sobf_out_buf (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   load_en,
   input  wire sobf_pkg::res_load_type load,
   output logic                        room,
   sobf_rsp_if.source                  rsp_bus
);
   import sobf_pkg::*;

   logic [1:0]       cnt_ff, cnt_in;
   logic [PIX_W-1:0] e0_px_ff, e0_px_in, e1_px_ff, e1_px_in;
   logic             e0_last_ff, e0_last_in, e1_last_ff, e1_last_in;
   logic             beat;

   assign beat = (cnt_ff != 2'd0) && rsp_bus.ready;
   assign room = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_bus.ready);

   always_comb begin
      cnt_in     = cnt_ff;
      e0_px_in   = e0_px_ff;
      e0_last_in = e0_last_ff;
      e1_px_in   = e1_px_ff;
      e1_last_in = e1_last_ff;
      if (load_en) begin
         if (load.v0) begin
            e0_px_in   = load.px0;
            e0_last_in = 1'b0;
            e1_px_in   = load.px1;
            e1_last_in = load.last1;
            cnt_in     = load.v1 ? 2'd2 : 2'd1;
         end else begin
            e0_px_in   = load.px1;
            e0_last_in = load.last1;
            cnt_in     = 2'd1;
         end
      end else if (beat) begin
         e0_px_in   = e1_px_ff;
         e0_last_in = e1_last_ff;
         cnt_in     = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      e0_px_ff   <= e0_px_in;
      e0_last_ff <= e0_last_in;
      e1_px_ff   <= e1_px_in;
      e1_last_ff <= e1_last_in;
   end

   assign rsp_bus.valid          = cnt_ff != 2'd0;
   assign rsp_bus.filtered_pixel = e0_px_ff;
   assign rsp_bus.last_of_frame  = e0_last_ff;

endmodule
`default_nettype wire

// ----- sv/sobel_3x3_vertical_filter_top.sv -----
// a taken pixel is registered in s1, its results in the result buffer that offers them
// throughput: one pixel per cycle while the result buffer has room; a row-end pixel can give
//   two results for the single response port; the line store has one read and one write port
// reset: synchronous; the line store is zero-filled, and no pixel is taken until the fill
//   is done; frame size returns to 512 x 512 (clamped to the maximum)
`default_nettype none
`include "sobel_3x3_vertical_filter_top_macros.svh"
module sobel_3x3_vertical_filter_top #(
   parameter int unsigned MAX_WIDTH  = sobf_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_HEIGHT = sobf_pkg::DEF_MAX_HEIGHT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   sobf_req_if.sink    req_bus,
   sobf_rsp_if.source  rsp_bus,
   sobf_csr_if.sink    csr_bus
);
   import sobf_pkg::*;

   localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
   localparam int unsigned WD     = $clog2(MAX_WIDTH + 1);
   localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT + 1);
   localparam int unsigned ROW_X  = ROW_W + 1;

   logic [WD-1:0]     eff_w;
   logic [ROW_W-1:0]  eff_h;
   logic [ROW_X-1:0]  h_ext;

   logic [ADDR_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;

   logic              req_acc;
   logic              clr_busy;
   logic              col_wrap;
   logic              wrap_out;
   logic [ROW_X-1:0]  row_t;
   logic [ROW_X-1:0]  row_t2;
   logic [WD-1:0]     c_inc;

   logic              s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0] s1_c_ff, s1_c_in;
   logic [ROW_W-1:0]  s1_r_in;
   logic [PIX_W-1:0]  s1_pix_ff, s1_pix_in;
   logic              s1_r_ge1_ff, s1_r_ge1_in;
   logic              s1_r_ge2_ff, s1_r_ge2_in;
   logic              s1_r_eq_h_ff, s1_r_eq_h_in;
   logic              s1_c_zero_ff, s1_c_zero_in;
   logic              s1_last_col_ff, s1_last_col_in;
   logic              s1_go;

   logic [PIX_W-1:0]  top_p1_ff, top_p2_ff, bot_p1_ff, bot_p2_ff;
   logic [PIX_W-1:0]  wt0, wt1, wb0, wb1, nt;
   logic [LINE_W-1:0] rd_data;
   logic [LINE_W-1:0] wr_data;

   res_load_type      load;
   logic              has_res;
   logic              ob_room;
   logic              ob_load;

   sobf_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .eff_w   (eff_w),
      .eff_h   (eff_h)
   );

   // position of the incoming pixel and the position that follows it
   assign h_ext = ROW_X'(eff_h);

   always_comb begin
      col_wrap = WD'(col_ff) >= eff_w;
      row_t    = col_wrap ? (ROW_X'(row_ff) + ROW_X'(1)) : ROW_X'(row_ff);
      if (req_bus.frame_start) begin
         s1_c_in = '0;
         s1_r_in = '0;
      end else begin
         s1_c_in = col_wrap ? '0 : col_ff;
         s1_r_in = (row_t > h_ext) ? '0 : ROW_W'(row_t);
      end
      c_inc    = WD'(s1_c_in) + WD'(1);
      wrap_out = c_inc >= eff_w;
      col_in   = wrap_out ? '0 : ADDR_W'(c_inc);
      row_t2   = wrap_out ? (ROW_X'(s1_r_in) + ROW_X'(1)) : ROW_X'(s1_r_in);
      row_in   = (row_t2 > h_ext) ? '0 : ROW_W'(row_t2);

      s1_r_ge1_in    = s1_r_in != '0;
      s1_r_ge2_in    = (s1_r_in != '0) && (s1_r_in != ROW_W'(1));
      s1_r_eq_h_in   = s1_r_in == eff_h;
      s1_c_zero_in   = s1_c_in == '0;
      s1_last_col_in = WD'(s1_c_in) == (eff_w - WD'(1));
      s1_pix_in      = (s1_r_in < eff_h) ? req_bus.pixel_value : '0;
   end

   assign req_bus.ready = !clr_busy && (!s1_valid_ff || s1_go);
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign s1_valid_in   = req_acc || (s1_valid_ff && !s1_go);

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (req_acc) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_c_ff        <= s1_c_in;
         s1_pix_ff      <= s1_pix_in;
         s1_r_ge1_ff    <= s1_r_ge1_in;
         s1_r_ge2_ff    <= s1_r_ge2_in;
         s1_r_eq_h_ff   <= s1_r_eq_h_in;
         s1_c_zero_ff   <= s1_c_zero_in;
         s1_last_col_ff <= s1_last_col_in;
      end
   end

   sobf_line_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_line_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_acc),
      .rd_addr (s1_c_in),
      .rd_data (rd_data),
      .wr_en   (s1_go),
      .wr_addr (s1_c_ff),
      .wr_data (wr_data),
      .busy    (clr_busy)
   );

   // window and kernel
   always_comb begin
      nt      = s1_r_ge2_ff ? rd_data[LINE_W-1:PIX_W] : '0;
      wt0     = s1_c_zero_ff ? '0 : top_p1_ff;
      wt1     = s1_c_zero_ff ? '0 : top_p2_ff;
      wb0     = s1_c_zero_ff ? '0 : bot_p1_ff;
      wb1     = s1_c_zero_ff ? '0 : bot_p2_ff;
      wr_data = {rd_data[PIX_W-1:0], s1_pix_ff};

      load.v0    = s1_r_ge1_ff && !s1_c_zero_ff;
      load.v1    = s1_r_ge1_ff && s1_last_col_ff;
      load.px0   = sobf_grad(wt0, wt1, nt, wb0, wb1, s1_pix_ff);
      load.px1   = sobf_grad(wt1, nt, '0, wb1, s1_pix_ff, '0);
      load.last1 = s1_r_eq_h_ff;

      has_res = load.v0 || load.v1;
      s1_go   = s1_valid_ff && (!has_res || ob_room);
      ob_load = s1_go && has_res;
   end

   always_ff @(posedge clock) begin
      if (s1_go) begin
         top_p1_ff <= wt1;
         top_p2_ff <= nt;
         bot_p1_ff <= wb1;
         bot_p2_ff <= s1_pix_ff;
      end
   end

   sobf_out_buf u_out_buf (
      .clock   (clock),
      .reset   (reset),
      .load_en (ob_load),
      .load    (load),
      .room    (ob_room),
      .rsp_bus (rsp_bus)
   );

   `SOBF_ASSERT_IMPL(a_clr_empty, clock, reset, clr_busy, !s1_valid_ff, "pixel in flight during line store fill")
   `SOBF_ASSERT_NEXT(a_s1_hold, clock, reset, s1_valid_ff && !s1_go, s1_valid_ff && $stable(s1_c_ff), "stalled pixel lost its column")
   `SOBF_ASSERT_IMPL(a_last_row, clock, reset, s1_valid_ff && s1_r_eq_h_ff, s1_r_ge1_ff, "drain row seen at row zero")

endmodule
`default_nettype wire

// ----- bench/sobel_3x3_vertical_filter_checker.sv -----
`timescale 1ns / 1ps
// scoreboard for the vertical sobel filter: follows register writes and pixel beats,
// predicts every filtered beat and compares it with the beats the block sends
// depends on sobf_pkg and the channel interfaces of sobf_if.sv
module sobel_3x3_vertical_filter_checker (
   input  logic clock,
   input  logic reset,
   sobf_req_if  req_bus,
   sobf_rsp_if  rsp_bus,
   sobf_csr_if  csr_bus,
   output int   mismatches,
   output int   pending_beats
);
   import sobf_pkg::*;

   localparam int unsigned LINE_LEN  = DEF_MAX_WIDTH;
   localparam int unsigned ROW_LIMIT = DEF_MAX_HEIGHT;
   localparam int PRINT_CAP = 100;

   typedef struct packed {
      logic [PIX_W-1:0] level;
      logic             frame_end;
   } filtered_beat_type;

   filtered_beat_type expected_gradients [$];
   logic [PIX_W-1:0]  row_above [LINE_LEN];
   logic [PIX_W-1:0]  row_prev [LINE_LEN];
   logic [PIX_W-1:0]  win [3][3];
   int unsigned       row_pos;
   int unsigned       col_pos;
   logic [DIM_W-1:0]  width_reg;
   logic [DIM_W-1:0]  height_reg;

   function automatic int unsigned active_dim(input logic [DIM_W-1:0] v,
                                              input int unsigned limit);
      if (v == '0) return 1;
      if (32'(v) > limit) return limit;
      return 32'(v);
   endfunction

   function automatic logic [PIX_W-1:0] column_gradient(input int t0, input int t1,
                                                         input int t2, input int b0,
                                                         input int b1, input int b2);
      int s;
      s = (b0 + 2 * b1 + b2) - (t0 + 2 * t1 + t2);
      if (s < 0) s = 0;
      else if (s > int'(PIX_MAX)) s = int'(PIX_MAX);
      return s[PIX_W-1:0];
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("%0t mismatch: %s", $time, what);
   endtask

   task automatic predict_gradients(input logic [PIX_W-1:0] pix, input logic fs);
      int unsigned       w;
      int unsigned       h;
      int unsigned       r;
      int unsigned       c;
      logic [PIX_W-1:0]  top_px;
      logic [PIX_W-1:0]  mid_px;
      logic [PIX_W-1:0]  bot_px;
      filtered_beat_type beat;
      w = active_dim(width_reg, LINE_LEN);
      h = active_dim(height_reg, ROW_LIMIT);
      if (fs) begin
         row_pos = 0;
         col_pos = 0;
      end else begin
         if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
         end
         if (row_pos > h) row_pos = 0;
      end
      r = row_pos;
      c = col_pos;
      // rows above the frame top read as zero, the drain row brings zeros
      top_px = (r >= 2) ? row_above[c] : '0;
      mid_px = (r >= 1) ? row_prev[c] : '0;
      bot_px = (r < h) ? pix : '0;
      if (c == 0) win = '{default: '0};
      for (int k = 0; k < 3; k++) begin
         win[k][0] = win[k][1];
         win[k][1] = win[k][2];
      end
      win[0][2] = top_px;
      win[1][2] = mid_px;
      win[2][2] = bot_px;
      row_above[c] = row_prev[c];
      row_prev[c] = bot_px;
      if (r >= 1) begin
         if (c >= 1) begin
            beat.level = column_gradient(win[0][0], win[0][1], win[0][2],
                                         win[2][0], win[2][1], win[2][2]);
            beat.frame_end = 1'b0;
            expected_gradients.push_back(beat);
         end
         // last column of the row, right neighbour outside the frame
         if (c == w - 1) begin
            beat.level = column_gradient(win[0][1], win[0][2], 0, win[2][1], win[2][2], 0);
            beat.frame_end = (r == h);
            expected_gradients.push_back(beat);
         end
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos = r + 1;
         if (row_pos > h) row_pos = 0;
      end
   endtask

   always @(posedge clock) begin
      filtered_beat_type want;
      if (reset) begin
         expected_gradients.delete();
         for (int i = 0; i < LINE_LEN; i++) begin
            row_above[i] = '0;
            row_prev[i] = '0;
         end
         win = '{default: '0};
         row_pos = 0;
         col_pos = 0;
         width_reg = DEF_FRAME_WIDTH;
         height_reg = DEF_FRAME_HEIGHT;
         mismatches = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_gradients.size() == 0) begin
               report_mismatch($sformatf("unexpected beat, level %0d last %0b",
                                         rsp_bus.filtered_pixel, rsp_bus.last_of_frame));
            end else begin
               want = expected_gradients.pop_front();
               if (rsp_bus.filtered_pixel !== want.level ||
                   rsp_bus.last_of_frame !== want.frame_end) begin
                  report_mismatch($sformatf("level %0d (want %0d), last %0b (want %0b)",
                                            rsp_bus.filtered_pixel, want.level,
                                            rsp_bus.last_of_frame, want.frame_end));
               end
            end
         end
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_reg_type'(csr_bus.index))
               REG_FRAME_WIDTH: begin
                  width_reg = csr_bus.data;
               end
               REG_FRAME_HEIGHT: begin
                  height_reg = csr_bus.data;
               end
               default: begin
               end
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            predict_gradients(req_bus.pixel_value, req_bus.frame_start);
         end
      end
      pending_beats = expected_gradients.size();
   end

endmodule

// ----- bench/sobel_3x3_vertical_filter_top_test.sv -----
`timescale 1ns / 1ps
// stimulus and verdict for the vertical sobel filter: pixel beats in bursts, register
// writes between phases and a stalling response side; the checker module does the checking
// depends on sobf_pkg, sobf_if.sv, the filter rtl and sobel_3x3_vertical_filter_checker
module sobel_3x3_vertical_filter_top_test;
   import sobf_pkg::*;

   localparam int RANDOM_PIXELS = 120;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 6;
   localparam int FRAME_CAP     = 60;

   typedef enum {SEQ_FRAMES, SEQ_BROKEN, SEQ_CARRY_ON, SEQ_NOISE} sequence_kind_type;
   typedef enum {STALL_NONE, STALL_HALF, STALL_RARE, STALL_HEAVY} stall_mode_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   int               mismatches;
   int               pending_beats;
   int               pixels_sent = 0;
   int               burst_left = 0;
   logic [DIM_W-1:0] cur_width = DEF_FRAME_WIDTH;
   logic [DIM_W-1:0] cur_height = DEF_FRAME_HEIGHT;

   sobf_req_if req_bus ();
   sobf_rsp_if rsp_bus ();
   sobf_csr_if csr_bus ();

   sobel_3x3_vertical_filter_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   sobel_3x3_vertical_filter_checker scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .mismatches    (mismatches),
      .pending_beats (pending_beats)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned frame_dim(input logic [DIM_W-1:0] v);
      if (v == '0) return 1;
      if (32'(v) > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
      return 32'(v);
   endfunction

   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return PIX_MAX;
         default: return PIX_W'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic fs);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 48);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.pixel_value <= pix;
      req_bus.frame_start <= fs;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      pixels_sent++;
   endtask

   task automatic write_reg(input csr_reg_type which, input logic [DIM_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= which;
      csr_bus.data <= value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      if (which == REG_FRAME_WIDTH) cur_width = value;
      else cur_height = value;
   endtask

   // stop sending and let the block run dry
   task automatic settle();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_beats != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [PIX_W-1:0]  pattern [9];
      logic [DIM_W-1:0]  pick;
      sequence_kind_type kind;
      int                stop_at;
      int                span;
      int                count;
      int                roll;
      int unsigned       frame_len;
      pattern = '{8'd0, 8'd255, 8'd1, 8'd255, 8'd0, 8'd2, 8'd255, 8'd255, 8'd255};
      req_bus.valid = 1'b0;
      req_bus.pixel_value = '0;
      req_bus.frame_start = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_FRAME_WIDTH;
      csr_bus.data = '0;
      repeat (10) @(negedge clock);
      reset <= 1'b0;

      // 3x2 frame with clamping both ways, drain row levels ignored
      write_reg(REG_FRAME_WIDTH, 10'd3);
      write_reg(REG_FRAME_HEIGHT, 10'd2);
      for (int i = 0; i < 9; i++) send_pixel(pattern[i], i == 0);
      settle();

      // zero sizes act as one; the stream carries on into a new frame without a start flag
      write_reg(REG_FRAME_WIDTH, 10'd0);
      write_reg(REG_FRAME_HEIGHT, 10'd0);
      send_pixel(8'd200, 1'b1);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      settle();

      // oversize saturates, then shrink width and height part way through
      write_reg(REG_FRAME_WIDTH, 10'd1023);
      write_reg(REG_FRAME_HEIGHT, 10'd1023);
      for (int i = 0; i < 5; i++) send_pixel(pick_pixel(), i == 0);
      settle();
      write_reg(REG_FRAME_WIDTH, 10'd2);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd0, 1'b0);
      settle();
      write_reg(REG_FRAME_HEIGHT, 10'd1);
      send_pixel(8'd17, 1'b0);
      send_pixel(8'd255, 1'b0);
      send_pixel(8'd90, 1'b1);
      send_pixel(8'd0, 1'b0);
      settle();

      // short first row, then widen so the second row runs over every column
      write_reg(REG_FRAME_WIDTH, 10'd2);
      write_reg(REG_FRAME_HEIGHT, 10'd2);
      send_pixel(pick_pixel(), 1'b1);
      send_pixel(pick_pixel(), 1'b0);
      settle();
      write_reg(REG_FRAME_WIDTH, 10'd512);
      for (int i = 0; i < 512; i++) send_pixel(pick_pixel(), 1'b0);

      stop_at = pixels_sent + RANDOM_PIXELS;
      while (pixels_sent < stop_at) begin
         settle();
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 14))
               0: pick = 10'd1023;
               1: pick = 10'd512;
               2: pick = 10'd0;
               default: pick = DIM_W'($urandom_range(1, 8));
            endcase
            write_reg(REG_FRAME_WIDTH, pick);
         end
         if ($urandom_range(0, 2) != 0) begin
            case ($urandom_range(0, 14))
               0: pick = 10'd1023;
               1: pick = 10'd600;
               2: pick = 10'd0;
               default: pick = DIM_W'($urandom_range(1, 6));
            endcase
            write_reg(REG_FRAME_HEIGHT, pick);
         end
         frame_len = frame_dim(cur_width) * (frame_dim(cur_height) + 1);
         span = (frame_len > FRAME_CAP) ? $urandom_range(1, FRAME_CAP) : frame_len;
         roll = $urandom_range(0, 9);
         if (roll < 7) kind = SEQ_FRAMES;
         else if (roll == 7) kind = SEQ_BROKEN;
         else if (roll == 8) kind = SEQ_CARRY_ON;
         else kind = SEQ_NOISE;
         case (kind)
            SEQ_FRAMES: begin
               repeat ($urandom_range(1, 3)) begin
                  for (int i = 0; i < span; i++) send_pixel(pick_pixel(), i == 0);
               end
            end
            SEQ_BROKEN: begin
               count = $urandom_range(1, 2 * span);
               for (int i = 0; i < count; i++) send_pixel(pick_pixel(), i == 0);
            end
            SEQ_CARRY_ON: begin
               for (int i = 0; i < span; i++) send_pixel(pick_pixel(), 1'b0);
            end
            SEQ_NOISE: begin
               count = $urandom_range(1, 40);
               for (int i = 0; i < count; i++) begin
                  send_pixel(pick_pixel(), $urandom_range(0, 7) == 0);
               end
            end
            default: begin
            end
         endcase
      end

      settle();
      repeat (20) @(negedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // response side stalls in randomly chosen modes, each held for a random span
   initial begin
      stall_mode_type mode;
      int             left;
      rsp_bus.ready = 1'b0;
      forever begin
         mode = stall_mode_type'($urandom_range(0, 3));
         left = $urandom_range(20, 200);
         repeat (left) begin
            @(negedge clock);
            case (mode)
               STALL_NONE: rsp_bus.ready <= 1'b1;
               STALL_HALF: rsp_bus.ready <= ($urandom_range(0, 1) != 0);
               STALL_RARE: rsp_bus.ready <= ($urandom_range(0, 9) != 0);
               STALL_HEAVY: rsp_bus.ready <= ($urandom_range(0, 15) == 0);
               default: rsp_bus.ready <= 1'b1;
            endcase
         end
      end
   end

   initial begin
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("watchdog: no beat for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

endmodule

// ----- sobel_3x3_vertical_filter_top.f -----
+incdir+sv
sv/sobf_pkg.sv
sv/sobf_if.sv
sv/sobf_csr.sv
sv/sobf_line_mem.sv
sv/sobf_out_buf.sv
sv/sobel_3x3_vertical_filter_top.sv
bench/sobel_3x3_vertical_filter_checker.sv
bench/sobel_3x3_vertical_filter_top_test.sv
